// ===== src/dttf_pkg.sv =====
package dttf_pkg;

	// Number format
	localparam int INT_BITS        = 16;
	localparam int FRAC_BITS       = 16;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int MAX_LEN         = 255;

	localparam int VALUE_W = INT_BITS + FRAC_BITS + 1;
	localparam int FDIG_W  = 30;
	localparam int FCNT_W  = 4;
	localparam int POS_W   = 8;
	localparam int STEP_W  = $clog2(FRAC_BITS + 1);

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Parse phases
	typedef enum logic [6:0] {
		PH_SKIP   = 7'b0000001,
		PH_SIGNED = 7'b0000010,
		PH_POINT  = 7'b0000100,
		PH_INT    = 7'b0001000,
		PH_FRAC   = 7'b0010000,
		PH_DONE   = 7'b0100000,
		PH_BAD    = 7'b1000000
	} phase_t;

	// Snapshot of the parser after the current character
	typedef struct packed {
		logic                ok;
		logic                negative;
		logic                saturated;
		logic [INT_BITS-1:0] int_acc;
		logic [FDIG_W-1:0]   frac_digits;
		logic [FCNT_W-1:0]   frac_count;
		logic [POS_W-1:0]    end_pos;
	} scan_res_t;

	// Power of ten for a fraction digit count
	function automatic logic [FDIG_W-1:0] pow10(input logic [FCNT_W-1:0] n);
		logic [FDIG_W-1:0] r;
		case (n)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

endpackage

// ===== src/dttf_scan.sv =====
module dttf_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          character,
	input  logic                is_last,
	output dttf_pkg::scan_res_t res
);
	import dttf_pkg::*;

	phase_t                phase_q, phase_d;
	logic                  neg_q, neg_d;
	logic                  sat_q, sat_d;
	logic [INT_BITS-1:0]   int_q, int_d;
	logic [FDIG_W-1:0]     fdig_q, fdig_d;
	logic [FCNT_W-1:0]     fcnt_q, fcnt_d;
	logic [POS_W-1:0]      pos_q, pos_after;
	logic [POS_W-1:0]      endp_q, endp_d;

	logic                  dig, spc, sgn, pnt;
	logic [3:0]            dval;
	logic [INT_BITS+3:0]   int_next;
	logic                  int_sat;
	logic [INT_BITS-1:0]   int_add;
	logic [FDIG_W-1:0]     fdig_add;
	logic [FCNT_W-1:0]     fcnt_add;

	// Classify the character
	assign dig  = (character >= CH_ZERO) && (character <= CH_NINE);
	assign spc  = (character == CH_SPACE) || ((character >= CH_TAB) && (character <= CH_CR));
	assign sgn  = (character == CH_PLUS) || (character == CH_MINUS);
	assign pnt  = (character == CH_POINT);
	assign dval = character[3:0];

	assign pos_after = (pos_q < POS_W'(MAX_LEN)) ? pos_q + POS_W'(1) : POS_W'(MAX_LEN);

	// Integer digit: times ten by shift-add, clamp on overflow
	always_comb begin
		int_next = ({4'd0, int_q} << 3) + ({4'd0, int_q} << 1) + (INT_BITS+4)'(dval);
		int_sat  = sat_q || (int_next > (INT_BITS+4)'({INT_BITS{1'b1}}));
		int_add  = int_sat ? {INT_BITS{1'b1}} : int_next[INT_BITS-1:0];
	end

	// Fraction digit: drop digits past the limit
	always_comb begin
		if (fcnt_q < FCNT_W'(MAX_FRAC_DIGITS)) begin
			fdig_add = (fdig_q << 3) + (fdig_q << 1) + FDIG_W'(dval);
			fcnt_add = fcnt_q + FCNT_W'(1);
		end else begin
			fdig_add = fdig_q;
			fcnt_add = fcnt_q;
		end
	end

	// Advance the phase for one character
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		sat_d   = sat_q;
		int_d   = int_q;
		fdig_d  = fdig_q;
		fcnt_d  = fcnt_q;
		endp_d  = endp_q;
		case (phase_q)
			PH_SKIP: begin
				if (spc) begin
					phase_d = PH_SKIP;
				end else if (sgn) begin
					neg_d   = (character == CH_MINUS);
					phase_d = PH_SIGNED;
				end else if (dig) begin
					int_d   = int_add;
					sat_d   = int_sat;
					endp_d  = pos_after;
					phase_d = PH_INT;
				end else if (pnt) begin
					phase_d = PH_POINT;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_SIGNED: begin
				if (dig) begin
					int_d   = int_add;
					sat_d   = int_sat;
					endp_d  = pos_after;
					phase_d = PH_INT;
				end else if (pnt) begin
					phase_d = PH_POINT;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_POINT: begin
				if (dig) begin
					fdig_d  = fdig_add;
					fcnt_d  = fcnt_add;
					endp_d  = pos_after;
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_BAD;
				end
			end
			PH_INT: begin
				if (dig) begin
					int_d  = int_add;
					sat_d  = int_sat;
					endp_d = pos_after;
				end else if (pnt) begin
					endp_d  = pos_after;
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					fdig_d = fdig_add;
					fcnt_d = fcnt_add;
					endp_d = pos_after;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Hand the post-character view to the sequencer
	always_comb begin
		res.ok          = (phase_d == PH_INT) || (phase_d == PH_FRAC) || (phase_d == PH_DONE);
		res.negative    = neg_d;
		res.saturated   = sat_d;
		res.int_acc     = int_d;
		res.frac_digits = fdig_d;
		res.frac_count  = fcnt_d;
		res.end_pos     = endp_d;
	end

	// Update on each item, restart after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			sat_q   <= 1'b0;
			int_q   <= '0;
			fdig_q  <= '0;
			fcnt_q  <= '0;
			pos_q   <= '0;
			endp_q  <= '0;
		end else if (take) begin
			if (is_last) begin
				phase_q <= PH_SKIP;
				neg_q   <= 1'b0;
				sat_q   <= 1'b0;
				int_q   <= '0;
				fdig_q  <= '0;
				fcnt_q  <= '0;
				pos_q   <= '0;
				endp_q  <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				sat_q   <= sat_d;
				int_q   <= int_d;
				fdig_q  <= fdig_d;
				fcnt_q  <= fcnt_d;
				pos_q   <= pos_after;
				endp_q  <= endp_d;
			end
		end
	end

endmodule

// ===== src/dttf_div.sv =====
module dttf_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [dttf_pkg::FDIG_W-1:0]          digits,
	input  logic [dttf_pkg::FCNT_W-1:0]          count,
	output logic                                 done,
	output logic [dttf_pkg::FRAC_BITS-1:0]       quotient
);
	import dttf_pkg::*;

	// digits < 10^count, so the remainder starts as digits and
	// FRAC_BITS zero bits are shifted in, one quotient bit per cycle
	logic [FDIG_W-1:0]    rem_q;
	logic [FDIG_W-1:0]    dvs_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic [FDIG_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q, 1'b0} - {1'b0, dvs_q};
	assign fits  = !trial[FDIG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(FRAC_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Restoring step on the shared subtractor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= digits;
			dvs_q <= pow10(count);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[FDIG_W-1:0] : {rem_q[FDIG_W-2:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done     = busy_q && (step_q == STEP_W'(FRAC_BITS - 1));
	assign quotient = quo_q;

endmodule

// ===== src/decimal_text_to_fixed_parser_core.sv =====
// Parses a decimal string given one character per item into a signed fixed-point
// value with 16 integer and 16 fraction bits. Each character that is not flagged
// last is taken and the block stays ready for the next one. The last character
// starts the fraction scaling, a restoring divide by 10^n that yields one quotient
// bit per cycle on a shared subtractor, so the block holds in_ready low through its
// 16 divide steps and the load of the result register, or only through that load
// when the string is rejected. The load cycle stretches for as long as the
// previous result still waits for out_ready. The result then waits in an output
// register for out_ready while the next string may already be fed in.
module decimal_text_to_fixed_parser_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           character,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dttf_pkg::VALUE_W-1:0]  value,
	output logic [dttf_pkg::POS_W-1:0]           consumed,
	output logic                                 valid_res,
	output logic                                 overflow
);
	import dttf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} seq_t;

	seq_t                  st_q;
	scan_res_t             scan;
	logic                  take;
	logic                  div_start;
	logic                  div_done;
	logic [FRAC_BITS-1:0]  quo;

	logic                  ok_q, neg_q, sat_q;
	logic [INT_BITS-1:0]   int_q;
	logic [POS_W-1:0]      endp_q;

	logic                  oval_q;
	logic [VALUE_W-1:0]    value_q;
	logic [POS_W-1:0]      cons_q;
	logic                  vres_q, ovf_q;
	logic                  load_out;
	logic [VALUE_W-1:0]    mag;

	assign in_ready  = (st_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign div_start = take && is_last && scan.ok;
	assign load_out  = (st_q == ST_HOLD) && (!oval_q || out_ready);

	dttf_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.character (character),
		.is_last   (is_last),
		.res       (scan)
	);

	dttf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.digits   (scan.frac_digits),
		.count    (scan.frac_count),
		.done     (div_done),
		.quotient (quo)
	);

	// Sequence: take characters, divide after the last unless rejected, then hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (take && is_last) begin
						st_q <= scan.ok ? ST_DIV : ST_HOLD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the integer part and flags of the finished string
	always_ff @(posedge clk) begin
		if (take && is_last) begin
			ok_q   <= scan.ok;
			neg_q  <= scan.negative;
			sat_q  <= scan.saturated;
			int_q  <= scan.int_acc;
			endp_q <= scan.end_pos;
		end
	end

	// Combine integer and fraction, apply the sign
	assign mag = {1'b0, int_q, quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (load_out) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (ok_q) begin
				value_q <= neg_q ? (VALUE_W'(0) - mag) : mag;
				cons_q  <= endp_q;
				vres_q  <= 1'b1;
				ovf_q   <= sat_q;
			end else begin
				value_q <= '0;
				cons_q  <= '0;
				vres_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign out_valid = oval_q;
	assign value     = value_q;
	assign consumed  = cons_q;
	assign valid_res = vres_q;
	assign overflow  = ovf_q;

endmodule

// ===== tb/decimal_text_to_fixed_parser_core_test.sv =====
module decimal_text_to_fixed_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dttf_pkg::*;

	typedef struct {
		logic [7:0]  ch;
		logic        last;
		int unsigned gap;
		bit          drain;
	} char_item_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          consumed;
		logic                      valid_res;
		logic                      overflow;
	} parse_result_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic [7:0]                character = 8'h00;
	logic                      is_last   = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          consumed;
	logic                      valid_res;
	logic                      overflow;

	char_item_t    char_q[$];
	parse_result_t pending_results[$];
	parse_result_t oldest;
	logic [7:0]    line_q[$];
	logic          char_taken = 1'b0;
	int unsigned   err_cnt = 0;
	int unsigned   queued_chars = 0;
	int unsigned   stall_left = 0;
	int unsigned   steady_left = 0;

	// Parser state as predicted from the accepted characters
	phase_t              scan_ph;
	logic                scan_neg;
	logic [INT_BITS-1:0] int_acc;
	logic [FDIG_W-1:0]   frac_dig;
	logic [FCNT_W-1:0]   frac_cnt;
	logic [POS_W-1:0]    scan_pos;
	logic [POS_W-1:0]    num_end;
	logic                int_sat;

	decimal_text_to_fixed_parser_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.consumed  (consumed),
		.valid_res (valid_res),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] blank_char();
		int unsigned r;
		r = $urandom_range(8, 13);
		return (r == 8) ? CH_SPACE : 8'(r);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	task automatic clear_scan();
		scan_ph  = PH_SKIP;
		scan_neg = 1'b0;
		int_acc  = '0;
		frac_dig = '0;
		frac_cnt = '0;
		scan_pos = '0;
		num_end  = '0;
		int_sat  = 1'b0;
	endtask

	// Accumulate an integer digit, clamp at the top of the integer range
	task automatic take_int_digit(input logic [3:0] d);
		logic [63:0] nxt;
		logic [63:0] top;
		nxt = 64'(int_acc) * 64'd10 + 64'(d);
		top = (64'd1 << INT_BITS) - 64'd1;
		if (int_sat || nxt > top) begin
			int_acc = top[INT_BITS-1:0];
			int_sat = 1'b1;
		end else begin
			int_acc = nxt[INT_BITS-1:0];
		end
	endtask

	// Keep fraction digits up to the limit, drop the rest
	task automatic take_frac_digit(input logic [3:0] d);
		if (frac_cnt < FCNT_W'(MAX_FRAC_DIGITS) && frac_cnt < 4'd9) begin
			frac_dig = frac_dig * 30'd10 + 30'(d);
			frac_cnt = frac_cnt + 1'b1;
		end
	endtask

	// Advance the parser by one character; queue the result on the last one
	task automatic scan_char(input logic [7:0] c, input logic last);
		logic [POS_W-1:0] pos_next;
		logic             dig;
		logic [63:0]      scale;
		logic [63:0]      frac;
		logic [63:0]      mag;
		parse_result_t    res;
		int               k;
		pos_next = (scan_pos < POS_W'(MAX_LEN)) ? scan_pos + 1'b1 : POS_W'(MAX_LEN);
		dig = (c >= CH_ZERO && c <= CH_NINE);
		case (scan_ph)
			PH_SKIP: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					scan_ph = PH_SKIP;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					scan_neg = (c == CH_MINUS);
					scan_ph = PH_SIGNED;
				end else if (dig) begin
					take_int_digit(c[3:0]);
					num_end = pos_next;
					scan_ph = PH_INT;
				end else if (c == CH_POINT) begin
					scan_ph = PH_POINT;
				end else begin
					scan_ph = PH_BAD;
				end
			end
			PH_SIGNED: begin
				if (dig) begin
					take_int_digit(c[3:0]);
					num_end = pos_next;
					scan_ph = PH_INT;
				end else if (c == CH_POINT) begin
					scan_ph = PH_POINT;
				end else begin
					scan_ph = PH_BAD;
				end
			end
			PH_POINT: begin
				if (dig) begin
					take_frac_digit(c[3:0]);
					num_end = pos_next;
					scan_ph = PH_FRAC;
				end else begin
					scan_ph = PH_BAD;
				end
			end
			PH_INT: begin
				if (dig) begin
					take_int_digit(c[3:0]);
					num_end = pos_next;
				end else if (c == CH_POINT) begin
					num_end = pos_next;
					scan_ph = PH_FRAC;
				end else begin
					scan_ph = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					take_frac_digit(c[3:0]);
					num_end = pos_next;
				end else begin
					scan_ph = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		scan_pos = pos_next;
		if (last) begin
			res = '{default: '0};
			if (scan_ph inside {PH_INT, PH_FRAC, PH_DONE}) begin
				scale = 64'd1;
				for (k = 0; k < 9 && k < int'(frac_cnt); k++)
					scale = scale * 64'd10;
				frac = (64'(frac_dig) << FRAC_BITS) / scale;
				mag = (64'(int_acc) << FRAC_BITS) + frac;
				res.value = scan_neg ? -mag[VALUE_W-1:0] : mag[VALUE_W-1:0];
				res.consumed = num_end;
				res.valid_res = 1'b1;
				res.overflow = int_sat;
			end
			pending_results.push_back(res);
			clear_scan();
		end
	endtask

	task automatic put(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic put_byte(input logic [7:0] b);
		line_q.push_back(b);
	endtask

	// Move the built string into the item queue, last flag on its final byte
	task automatic send_line(input bit drain, input bit calm);
		char_item_t it;
		int         i;
		for (i = 0; i < line_q.size(); i++) begin
			it.ch    = line_q[i];
			it.last  = (i == line_q.size() - 1);
			it.gap   = calm ? 0 : pick_gap();
			it.drain = drain && (i == 0);
			char_q.push_back(it);
		end
		queued_chars += line_q.size();
		line_q.delete();
	endtask

	task automatic say(input string s);
		put(s);
		send_line(1'b0, 1'b0);
	endtask

	// Mostly well-formed numbers with random content, some noise and broken forms
	task automatic make_number();
		int unsigned kind;
		int unsigned n_int;
		int unsigned n_frac;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 6))
				put_byte(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3))
				put_byte(blank_char());
		case ($urandom_range(0, 2))
			0: put_byte(CH_PLUS);
			1: put_byte(CH_MINUS);
			default: begin
			end
		endcase
		if (kind < 18)
			put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		if (kind >= 18 && kind < 24) begin
			put_byte(CH_POINT);
			if ($urandom_range(0, 1))
				put_byte(8'h41 + 8'($urandom_range(0, 25)));
			return;
		end
		n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
		repeat (n_int)
			put_byte(rand_digit());
		if (n_int == 0 || $urandom_range(0, 9) < 6) begin
			put_byte(CH_POINT);
			n_frac = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
			if (n_int == 0 && n_frac == 0)
				n_frac = 1;
			repeat (n_frac)
				put_byte(rand_digit());
		end
		if ($urandom_range(0, 9) < 4)
			repeat ($urandom_range(1, 4))
				put_byte(8'($urandom_range(0, 255)));
	endtask

	// Strings near or past the position limit
	task automatic make_long();
		if ($urandom_range(0, 1)) begin
			repeat ($urandom_range(250, 300))
				put_byte(blank_char());
			put_byte(rand_digit());
		end else begin
			put_byte(rand_digit());
			put_byte(CH_POINT);
			repeat ($urandom_range(250, 300))
				put_byte(rand_digit());
		end
	endtask

	// Check results against the oldest prediction, then predict accepted items
	always @(posedge clk) begin
		if (!arst_n) begin
			char_taken <= 1'b0;
			clear_scan();
		end else begin
			char_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result value %0d consumed %0d valid_res %0b",
						$time, value, consumed, valid_res);
					err_cnt++;
				end else begin
					oldest = pending_results.pop_front();
					if (value !== oldest.value) begin
						$display("%0t: value expected %0d got %0d", $time, oldest.value, value);
						err_cnt++;
					end
					if (consumed !== oldest.consumed) begin
						$display("%0t: consumed expected %0d got %0d",
							$time, oldest.consumed, consumed);
						err_cnt++;
					end
					if (valid_res !== oldest.valid_res) begin
						$display("%0t: valid_res expected %0b got %0b",
							$time, oldest.valid_res, valid_res);
						err_cnt++;
					end
					if (overflow !== oldest.overflow) begin
						$display("%0t: overflow expected %0b got %0b",
							$time, oldest.overflow, overflow);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready)
				scan_char(character, is_last);
		end
	end

	// Present the next item once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || char_taken) begin
			if (char_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (char_q[0].gap != 0) begin
				in_valid <= 1'b0;
				char_q[0].gap = char_q[0].gap - 1;
			end else if (char_q[0].drain && pending_results.size() != 0) begin
				in_valid <= 1'b0;
			end else begin
				in_valid  <= 1'b1;
				character <= char_q[0].ch;
				is_last   <= char_q[0].last;
				void'(char_q.pop_front());
			end
		end
	end

	// Stall the result side at random, with stall-free stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (steady_left != 0) begin
			out_ready <= 1'b1;
			steady_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 19) == 0)
				steady_left = $urandom_range(50, 200);
			else if ($urandom_range(0, 2) == 0)
				stall_left = pick_gap();
		end
	end

	initial begin
		int unsigned lines;

		// Directed strings
		say("0");
		say("65535");
		say("-65536");
		say("+7.5");
		put_byte(CH_TAB);
		put_byte(8'h0A);
		put_byte(8'h0B);
		put_byte(8'h0C);
		put_byte(CH_CR);
		say(" 42");
		say("-0.0");
		say("--5");
		say("+-5");
		say(".");
		say(".5");
		say("-.25");
		say("12.");
		say("12.x");
		say("3.14159265358979");
		say("99999999999.999999999");
		say(" ");
		say("-");
		put("12");
		put_byte(8'h00);
		say(" 34");
		put_byte(8'h00);
		send_line(1'b0, 1'b0);
		say("abc");
		say("5e3");
		say("1.2.3");
		put("7");
		put_byte(8'hFF);
		send_line(1'b0, 1'b0);
		say(".-1");

		// Random strings; the first one, and now and then another, waits for all results to drain
		queued_chars = 0;
		lines = 0;
		while (queued_chars < 2000) begin
			if (lines == 30 || lines == 150 || $urandom_range(0, 149) == 0)
				make_long();
			else
				make_number();
			send_line(lines == 0 || $urandom_range(0, 49) == 0, $urandom_range(0, 4) == 0);
			lines++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
